// File: rtl/gcti_pkg.sv
// ----------------------------------------------------------------------------
// gcti_pkg
// Shared types and constants for the grid cell triangle indexer.
// ----------------------------------------------------------------------------
package gcti_pkg;

   localparam int unsigned PTS_W   = 9;
   localparam int unsigned CELL_W  = 8;
   localparam int unsigned IDX_W   = 24;
   localparam int unsigned SLOT_W  = 4;
   localparam int unsigned PLANE_W = 2 * PTS_W;
   localparam int unsigned FACES   = 12;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FACES - 1);

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type REG_X_POINTS = 2'd0;
   localparam csr_index_type REG_Y_POINTS = 2'd1;
   localparam csr_index_type REG_Z_POINTS = 2'd2;

   typedef struct packed {
      logic [PTS_W-1:0]   x_points;
      logic [PTS_W-1:0]   y_points;
      logic [PTS_W-1:0]   z_points;
      logic [PLANE_W-1:0] plane;
   } geom_type;

   typedef struct packed {
      logic [IDX_W-1:0] base;
      logic             bad;
   } cell_type;

   // corner offset bits {dz, dy, dx}
   typedef logic [2:0] corner_type;
   localparam corner_type CORNER_A = 3'b000;
   localparam corner_type CORNER_B = 3'b001;
   localparam corner_type CORNER_C = 3'b101;
   localparam corner_type CORNER_D = 3'b100;
   localparam corner_type CORNER_F = 3'b010;
   localparam corner_type CORNER_G = 3'b011;
   localparam corner_type CORNER_H = 3'b111;
   localparam corner_type CORNER_M = 3'b110;

   typedef struct packed {
      corner_type va;
      corner_type vb;
      corner_type vc;
   } face_type;

   localparam face_type FACE_TABLE [FACES] = '{
      '{CORNER_A, CORNER_B, CORNER_D},
      '{CORNER_D, CORNER_B, CORNER_C},
      '{CORNER_A, CORNER_B, CORNER_F},
      '{CORNER_F, CORNER_B, CORNER_G},
      '{CORNER_A, CORNER_F, CORNER_D},
      '{CORNER_D, CORNER_M, CORNER_F},
      '{CORNER_F, CORNER_G, CORNER_M},
      '{CORNER_M, CORNER_G, CORNER_H},
      '{CORNER_D, CORNER_C, CORNER_H},
      '{CORNER_D, CORNER_M, CORNER_H},
      '{CORNER_B, CORNER_C, CORNER_G},
      '{CORNER_C, CORNER_G, CORNER_H}
   };

   function automatic logic [IDX_W-1:0] corner_index(
      input logic [IDX_W-1:0]   base,
      input logic [PTS_W-1:0]   row,
      input logic [PLANE_W-1:0] plane,
      input corner_type         c
   );
      logic [IDX_W-1:0] sum;
      sum = base + IDX_W'(c[0]);
      if (c[1]) begin
         sum = sum + IDX_W'(row);
      end
      if (c[2]) begin
         sum = sum + IDX_W'(plane);
      end
      return sum;
   endfunction

endpackage

// File: rtl/gcti_csr.sv
// ----------------------------------------------------------------------------
// gcti_csr
// Grid size registers with write clamp, plus the registered plane stride.
// ----------------------------------------------------------------------------
module gcti_csr #(
   parameter int unsigned MAX_POINTS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  gcti_pkg::csr_index_type      csr_index,
   input  logic [gcti_pkg::PTS_W-1:0]   csr_data,
   output gcti_pkg::geom_type           geom
);
   import gcti_pkg::*;

   localparam int unsigned CLAMP = (MAX_POINTS > (2 ** PTS_W) - 1) ?
                                   (2 ** PTS_W) - 1 : MAX_POINTS;
   localparam logic [PTS_W-1:0] CLAMP_V = PTS_W'(CLAMP);
   localparam logic [PTS_W-1:0] RESET_PTS = PTS_W'(2);

   logic [PTS_W-1:0]   x_ff, y_ff, z_ff;
   logic [PTS_W-1:0]   x_in, y_in, z_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic [PTS_W-1:0]   wr_value;

   always_comb begin
      wr_value = (csr_data > CLAMP_V) ? CLAMP_V : csr_data;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_X_POINTS: x_in = wr_value;
            REG_Y_POINTS: y_in = wr_value;
            REG_Z_POINTS: z_in = wr_value;
            default: ;
         endcase
      end
      plane_in = PLANE_W'(x_ff) * PLANE_W'(y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= RESET_PTS;
         y_ff     <= RESET_PTS;
         z_ff     <= RESET_PTS;
         plane_ff <= PLANE_W'(4);
      end else begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         plane_ff <= plane_in;
      end
   end

   assign geom.x_points = x_ff;
   assign geom.y_points = y_ff;
   assign geom.z_points = z_ff;
   assign geom.plane    = plane_ff;

endmodule

// File: rtl/gcti_front.sv
// ----------------------------------------------------------------------------
// gcti_front
// Input register; forms the base vertex index and the range check.
// ----------------------------------------------------------------------------
module gcti_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gcti_pkg::CELL_W-1:0]   req_cell_x,
   input  logic [gcti_pkg::CELL_W-1:0]   req_cell_y,
   input  logic [gcti_pkg::CELL_W-1:0]   req_cell_z,
   input  gcti_pkg::geom_type            geom,
   output logic                          cell_valid,
   input  logic                          cell_take,
   output gcti_pkg::cell_type            cell_info
);
   import gcti_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [CELL_W-1:0] cx_ff, cy_ff, cz_ff;
   logic              load;
   logic [IDX_W-1:0]  row_part, plane_part;

   assign req_stall = in_valid_ff && !cell_take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!in_valid_ff || cell_take) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cx_ff <= req_cell_x;
         cy_ff <= req_cell_y;
         cz_ff <= req_cell_z;
      end
   end

   always_comb begin
      row_part       = IDX_W'(cy_ff) * IDX_W'(geom.x_points);
      plane_part     = IDX_W'(cz_ff) * IDX_W'(geom.plane);
      cell_info.base = IDX_W'(cx_ff) + row_part + plane_part;
      cell_info.bad  = !(({1'b0, cx_ff} + PTS_W'(1)) < geom.x_points &&
                         ({1'b0, cy_ff} + PTS_W'(1)) < geom.y_points &&
                         ({1'b0, cz_ff} + PTS_W'(1)) < geom.z_points);
   end

   assign cell_valid = in_valid_ff;

endmodule

// File: rtl/gcti_emit.sv
// ----------------------------------------------------------------------------
// gcti_emit
// Holds one cell, walks its 12 faces (one result if bad) into the result reg.
// ----------------------------------------------------------------------------
module gcti_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cell_valid,
   output logic                          cell_take,
   input  gcti_pkg::cell_type            cell_info,
   input  gcti_pkg::geom_type            geom,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gcti_pkg::IDX_W-1:0]    rsp_vertex_a,
   output logic [gcti_pkg::IDX_W-1:0]    rsp_vertex_b,
   output logic [gcti_pkg::IDX_W-1:0]    rsp_vertex_c,
   output logic [gcti_pkg::SLOT_W-1:0]   rsp_face_slot,
   output logic                          rsp_bad_cell,
   output logic                          rsp_last
);
   import gcti_pkg::*;

   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  base_ff, base_in;
   logic              bad_ff, bad_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  va_ff, vb_ff, vc_ff, va_in, vb_in, vc_in;
   logic [SLOT_W-1:0] fs_ff, fs_in;
   logic              bad_out_ff, bad_out_in;
   logic              last_ff, last_in;

   logic              out_free, advance, final_slot;
   face_type          face;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = busy_ff && out_free;
   assign final_slot = bad_ff || (slot_ff == LAST_SLOT);
   assign cell_take  = !busy_ff || (advance && final_slot);

   always_comb begin
      face = FACE_TABLE[0];
      if (slot_ff <= LAST_SLOT) begin
         face = FACE_TABLE[slot_ff];
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      base_in      = base_ff;
      bad_in       = bad_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      vc_in        = vc_ff;
      fs_in        = fs_ff;
      bad_out_in   = bad_out_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         bad_out_in   = bad_ff;
         last_in      = final_slot;
         slot_in      = slot_ff + SLOT_W'(1);
         if (bad_ff) begin
            va_in = '0;
            vb_in = '0;
            vc_in = '0;
            fs_in = '0;
         end else begin
            va_in = corner_index(base_ff, geom.x_points, geom.plane, face.va);
            vb_in = corner_index(base_ff, geom.x_points, geom.plane, face.vb);
            vc_in = corner_index(base_ff, geom.x_points, geom.plane, face.vc);
            fs_in = slot_ff;
         end
         if (final_slot) begin
            busy_in = 1'b0;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (cell_take && cell_valid) begin
         busy_in = 1'b1;
         base_in = cell_info.base;
         bad_in  = cell_info.bad;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff    <= base_in;
      bad_ff     <= bad_in;
      va_ff      <= va_in;
      vb_ff      <= vb_in;
      vc_ff      <= vc_in;
      fs_ff      <= fs_in;
      bad_out_ff <= bad_out_in;
      last_ff    <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vertex_a  = va_ff;
   assign rsp_vertex_b  = vb_ff;
   assign rsp_vertex_c  = vc_ff;
   assign rsp_face_slot = fs_ff;
   assign rsp_bad_cell  = bad_out_ff;
   assign rsp_last      = last_ff;

endmodule

// File: rtl/grid_cell_triangle_indexer.sv
// ----------------------------------------------------------------------------
// grid_cell_triangle_indexer
// Turns a grid cell coordinate into the twelve vertex-index triangles of
// that cell, or into one flagged error result for a cell outside the grid.
// ----------------------------------------------------------------------------
// A cell inside the grid produces twelve results, one per cycle while rsp is
// not stalled; a cell outside the grid produces one result. The single
// result register delivers one triangle a cycle while rsp is not stalled.
// A request passes through the input register, the cell registers and the
// result register before its first result appears. The input register
// takes the next cell while the current one is still being walked.
// A grid size write is usable by a cell accepted on the following cycle.
module grid_cell_triangle_indexer #(
   parameter int unsigned MAX_POINTS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gcti_pkg::CELL_W-1:0]   req_cell_x,
   input  logic [gcti_pkg::CELL_W-1:0]   req_cell_y,
   input  logic [gcti_pkg::CELL_W-1:0]   req_cell_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gcti_pkg::IDX_W-1:0]    rsp_vertex_a,
   output logic [gcti_pkg::IDX_W-1:0]    rsp_vertex_b,
   output logic [gcti_pkg::IDX_W-1:0]    rsp_vertex_c,
   output logic [gcti_pkg::SLOT_W-1:0]   rsp_face_slot,
   output logic                          rsp_bad_cell,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  gcti_pkg::csr_index_type       csr_index,
   input  logic [gcti_pkg::PTS_W-1:0]    csr_data
);
   import gcti_pkg::*;

   geom_type geom;
   cell_type cell_info;
   logic     cell_valid;
   logic     cell_take;

   assign csr_ready = 1'b1;

   gcti_csr #(
      .MAX_POINTS (MAX_POINTS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   gcti_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cell_x (req_cell_x),
      .req_cell_y (req_cell_y),
      .req_cell_z (req_cell_z),
      .geom       (geom),
      .cell_valid (cell_valid),
      .cell_take  (cell_take),
      .cell_info  (cell_info)
   );

   gcti_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .cell_valid    (cell_valid),
      .cell_take     (cell_take),
      .cell_info     (cell_info),
      .geom          (geom),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_vertex_a  (rsp_vertex_a),
      .rsp_vertex_b  (rsp_vertex_b),
      .rsp_vertex_c  (rsp_vertex_c),
      .rsp_face_slot (rsp_face_slot),
      .rsp_bad_cell  (rsp_bad_cell),
      .rsp_last      (rsp_last)
   );

`ifndef SYNTHESIS
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !rsp_bad_cell |-> rsp_face_slot == LAST_SLOT)
      else $error("last triangle not in final slot");

   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_cell |-> rsp_last && rsp_face_slot == '0 &&
         rsp_vertex_a == '0 && rsp_vertex_b == '0 && rsp_vertex_c == '0)
      else $error("malformed error result");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a cell's triangle burst");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> cell_valid)
      else $error("input stalled with empty input register");
`endif

endmodule
